// ----- sv/fac_pkg.sv -----
// fac_pkg: shared types and constants for the frustum box cull unit
// no dependencies
`timescale 1ns / 1ps
package fac_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_PLANES    = 6;
    localparam int COEF_W        = 33;
    localparam int COORD_W       = 32;
    localparam int PROD_W        = COEF_W + COORD_W;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic
    {
        ACT_LOAD = 1'b0,
        ACT_TEST = 1'b1
    } action_t;

    // one job, load or test, handed from front to back
    typedef struct packed
    {
        logic                        is_test;
        logic signed [COORD_W-1:0]   min_x;
        logic signed [COORD_W-1:0]   min_y;
        logic signed [COORD_W-1:0]   min_z;
        logic signed [COORD_W-1:0]   max_x;
        logic signed [COORD_W-1:0]   max_y;
        logic signed [COORD_W-1:0]   max_z;
    } job_t;
endpackage

// ----- sv/fac_front.sv -----
// fac_front: accepts items, applies matrix column loads to the plane store
// and queues every item for the back end; depends on fac_pkg
`timescale 1ns / 1ps
module fac_front
    import fac_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      action,
    input  logic [1:0]                column_index,
    input  logic signed [COORD_W-1:0] matrix_row_x,
    input  logic signed [COORD_W-1:0] matrix_row_y,
    input  logic signed [COORD_W-1:0] matrix_row_z,
    input  logic signed [COORD_W-1:0] matrix_row_w,
    input  logic signed [COORD_W-1:0] box_min_x,
    input  logic signed [COORD_W-1:0] box_min_y,
    input  logic signed [COORD_W-1:0] box_min_z,
    input  logic signed [COORD_W-1:0] box_max_x,
    input  logic signed [COORD_W-1:0] box_max_y,
    input  logic signed [COORD_W-1:0] box_max_z,
    input  logic                      back_busy,
    output logic signed [COEF_W-1:0]  coeffs [NUM_PLANES*4],
    output logic                      q_valid,
    output job_t                      q_job,
    input  logic                      q_take
);
    logic signed [COEF_W-1:0] coef_reg [NUM_PLANES*4];
    job_t                     q_mem [QUEUE_DEPTH];
    logic                     wp_reg, rp_reg;
    logic [1:0]               cnt_reg;
    logic                     accept;
    logic signed [COEF_W-1:0] w_e, x_e, y_e, z_e;

    // loads must not change planes under a pending test, so stall while work is queued or the back end is busy
    assign full    = (cnt_reg != 2'd0) || back_busy;
    assign accept  = push && !full;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_job   = q_mem[rp_reg];
    assign coeffs  = coef_reg;

    assign w_e = COEF_W'(matrix_row_w);
    assign x_e = COEF_W'(matrix_row_x);
    assign y_e = COEF_W'(matrix_row_y);
    assign z_e = COEF_W'(matrix_row_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES*4; i++)
            begin
                coef_reg[i] <= '0;
            end
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                q_mem[wp_reg] <= '{is_test: (action == ACT_TEST),
                                   min_x: box_min_x, min_y: box_min_y,
                                   min_z: box_min_z, max_x: box_max_x,
                                   max_y: box_max_y, max_z: box_max_z};
                wp_reg <= ~wp_reg;
                if (action == ACT_LOAD)
                begin
                    coef_reg[0*4 + column_index] <= w_e + x_e;
                    coef_reg[1*4 + column_index] <= w_e - x_e;
                    coef_reg[2*4 + column_index] <= w_e + y_e;
                    coef_reg[3*4 + column_index] <= w_e - y_e;
                    coef_reg[4*4 + column_index] <= w_e + z_e;
                    coef_reg[5*4 + column_index] <= w_e - z_e;
                end
            end
            if (q_take)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(accept) - 2'(q_take);
        end
    end
endmodule

// ----- sv/fac_back.sv -----
// fac_back: walks up to six planes of a test job, one plane per step, stopping at the first that culls,
// and writes one result per job, load or test, into a single-entry output queue; depends on fac_pkg
`timescale 1ns / 1ps
module fac_back
    import fac_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [COEF_W-1:0] coeffs [NUM_PLANES*4],
    input  logic                     q_valid,
    input  job_t                     q_job,
    output logic                     q_take,
    output logic                     busy,
    output logic                     empty,
    input  logic                     pop,
    output logic                     culled
);
    localparam int SUM_W = PROD_W + FRAC_BITS + 3;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_MUL,
        ST_SUM
    } state_t;

    state_t                   state_reg;
    logic [2:0]               plane_reg;
    logic                     cull_reg;
    job_t                     job_reg;
    logic                     out_valid_reg, out_cull_reg;
    logic signed [PROD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [COEF_W-1:0] d_reg;
    logic signed [COEF_W-1:0] ca, cb, cc;
    logic signed [COORD_W-1:0] vx, vy, vz;
    logic signed [SUM_W-1:0]  sum;
    logic                     last;

    assign empty  = !out_valid_reg;
    assign culled = out_cull_reg;
    assign busy   = (state_reg != ST_IDLE);
    assign q_take = (state_reg == ST_IDLE) && q_valid && !out_valid_reg;

    assign ca = coeffs[{plane_reg, 2'd0}];
    assign cb = coeffs[{plane_reg, 2'd1}];
    assign cc = coeffs[{plane_reg, 2'd2}];
    // positive vertex: max on axes with coefficient strictly above zero
    assign vx = (ca > 0) ? job_reg.max_x : job_reg.min_x;
    assign vy = (cb > 0) ? job_reg.max_y : job_reg.min_y;
    assign vz = (cc > 0) ? job_reg.max_z : job_reg.min_z;

    assign sum = SUM_W'(px_reg) + SUM_W'(py_reg) + SUM_W'(pz_reg)
               + (SUM_W'(d_reg) <<< FRAC_BITS);
    assign last = (plane_reg == 3'(NUM_PLANES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plane_reg     <= '0;
            cull_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_cull_reg  <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_take)
                    begin
                        job_reg   <= q_job;
                        plane_reg <= '0;
                        cull_reg  <= 1'b0;
                        if (q_job.is_test)
                        begin
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                            out_cull_reg  <= 1'b0;
                        end
                    end
                end
                ST_MUL:
                begin
                    px_reg    <= PROD_W'(ca * vx);
                    py_reg    <= PROD_W'(cb * vy);
                    pz_reg    <= PROD_W'(cc * vz);
                    d_reg     <= coeffs[{plane_reg, 2'd3}];
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    if (sum[SUM_W-1] || last)
                    begin
                        out_valid_reg <= 1'b1;
                        out_cull_reg  <= sum[SUM_W-1];
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        plane_reg <= plane_reg + 3'd1;
                        state_reg <= ST_MUL;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        plane_reg < 3'(NUM_PLANES)) else $error("plane index out of range");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> !out_valid_reg) else $error("job taken over pending result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_cull_reg)))
        else $error("result lost while waiting");
endmodule

// ----- sv/frustum_aabb_cull_unit.sv -----
// frustum_aabb_cull_unit: top level of the frustum box cull unit
// order: a load goes through the job queue into the result register; a test also passes
// a multiply and a sum state per plane examined, up to six; one item in flight, and no
// new item is taken while the job queue is occupied or the shared multiply/sum loop is busy
// reset: asynchronous active low, all plane coefficients zero, queues empty
// depends on fac_pkg, fac_front, fac_back
`timescale 1ns / 1ps
module frustum_aabb_cull_unit
    import fac_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      action,
    input  logic [1:0]                column_index,
    input  logic signed [COORD_W-1:0] matrix_row_x,
    input  logic signed [COORD_W-1:0] matrix_row_y,
    input  logic signed [COORD_W-1:0] matrix_row_z,
    input  logic signed [COORD_W-1:0] matrix_row_w,
    input  logic signed [COORD_W-1:0] box_min_x,
    input  logic signed [COORD_W-1:0] box_min_y,
    input  logic signed [COORD_W-1:0] box_min_z,
    input  logic signed [COORD_W-1:0] box_max_x,
    input  logic signed [COORD_W-1:0] box_max_y,
    input  logic signed [COORD_W-1:0] box_max_z,
    output logic                      empty,
    input  logic                      pop,
    output logic                      culled
);
    // plane store lives in the front, read by the back
    logic signed [COEF_W-1:0] coeffs [NUM_PLANES*4];
    logic                     q_valid, q_take, back_busy;
    job_t                     q_job;

    // front: transfer in, column loads, job queue
    fac_front u_front
    (
        .clk, .rst_n, .push, .full, .action, .column_index,
        .matrix_row_x, .matrix_row_y, .matrix_row_z, .matrix_row_w,
        .box_min_x, .box_min_y, .box_min_z, .box_max_x, .box_max_y, .box_max_z,
        .back_busy, .coeffs, .q_valid, .q_job, .q_take
    );

    // back: per-plane positive vertex test and result transfer out
    fac_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk, .rst_n, .coeffs, .q_valid, .q_job, .q_take,
        .busy(back_busy), .empty, .pop, .culled
    );
endmodule

// ----- tb/tb_frustum_aabb_cull_unit.sv -----
// tb_frustum_aabb_cull_unit: self-checking testbench for the frustum box cull unit
// predicts each culled flag from its own copy of the plane table and checks every transfer
// depends on fac_pkg and frustum_aabb_cull_unit
`timescale 1ns / 1ps
module tb_frustum_aabb_cull_unit;
    import fac_pkg::*;

    localparam int FRAC      = 16;
    localparam int CYCLE_CAP = 400000;
    localparam int HOLD_LEN  = 80;

    // one input item as the sender drives it
    typedef struct
    {
        action_t                   act;
        logic [1:0]                col;
        logic signed [COORD_W-1:0] mx;
        logic signed [COORD_W-1:0] my;
        logic signed [COORD_W-1:0] mz;
        logic signed [COORD_W-1:0] mw;
        logic signed [COORD_W-1:0] lo [3];
        logic signed [COORD_W-1:0] hi [3];
    } item_t;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic                      action;
    logic [1:0]                column_index;
    logic signed [COORD_W-1:0] matrix_row_x;
    logic signed [COORD_W-1:0] matrix_row_y;
    logic signed [COORD_W-1:0] matrix_row_z;
    logic signed [COORD_W-1:0] matrix_row_w;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
    logic                      empty;
    logic                      pop;
    logic                      culled;

    // predictor state: six planes by four coefficients, a b c d
    logic signed [COEF_W-1:0] plane_tab [NUM_PLANES*4];
    // culled flags still owed by the block, oldest first
    logic                     cull_due [$];
    int                       errs;
    int                       cycles;
    bit                       hold_req;

    frustum_aabb_cull_unit #(.FRAC_BITS(FRAC)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .column_index (column_index),
        .matrix_row_x (matrix_row_x),
        .matrix_row_y (matrix_row_y),
        .matrix_row_z (matrix_row_z),
        .matrix_row_w (matrix_row_w),
        .box_min_x    (box_min_x),
        .box_min_y    (box_min_y),
        .box_min_z    (box_min_z),
        .box_max_x    (box_max_x),
        .box_max_y    (box_max_y),
        .box_max_z    (box_max_z),
        .empty        (empty),
        .pop          (pop),
        .culled       (culled)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, counted in clock cycles
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // apply one accepted item to the plane table and return the flag it must produce
    function automatic logic cull_predict(input item_t it);
        logic signed [COEF_W-1:0] w33;
        logic signed [COEF_W-1:0] v33 [3];
        logic signed [71:0]       acc;
        logic signed [71:0]       ce;
        logic signed [71:0]       pe;
        logic                     hit;
        hit = 1'b0;
        if (it.act == ACT_LOAD)
        begin
            // entries are w plus or minus x, y, z, kept exactly at 33 bits
            w33    = it.mw;
            v33[0] = it.mx;
            v33[1] = it.my;
            v33[2] = it.mz;
            for (int a = 0; a < 3; a++)
            begin
                plane_tab[(2*a)*4 + it.col]   = w33 + v33[a];
                plane_tab[(2*a+1)*4 + it.col] = w33 - v33[a];
            end
            return 1'b0;
        end
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            acc = '0;
            for (int k = 0; k < 3; k++)
            begin
                ce = plane_tab[p*4 + k];
                // positive vertex: max on a strictly positive coefficient, else min
                pe = (plane_tab[p*4 + k] > 0) ? it.hi[k] : it.lo[k];
                acc = acc + ce * pe;
            end
            ce  = plane_tab[p*4 + 3];
            acc = acc + (ce <<< FRAC);
            if (acc < 0)
                hit = 1'b1;
        end
        return hit;
    endfunction

    // sender: drive at the falling edge, the transfer happens at the next rising edge
    task automatic send_item(input item_t it);
        @(negedge clk);
        push         = 1'b1;
        action       = it.act;
        column_index = it.col;
        matrix_row_x = it.mx;
        matrix_row_y = it.my;
        matrix_row_z = it.mz;
        matrix_row_w = it.mw;
        box_min_x    = it.lo[0];
        box_min_y    = it.lo[1];
        box_min_z    = it.lo[2];
        box_max_x    = it.hi[0];
        box_max_y    = it.hi[1];
        box_max_z    = it.hi[2];
        #1;
        while (full)
        begin
            @(negedge clk);
            #1;
        end
        cull_due.push_back(cull_predict(it));
        @(posedge clk);
    endtask

    // idle between items: mostly none, sometimes short, rarely long
    task automatic sender_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 30);
        if (n > 0)
        begin
            @(negedge clk);
            push = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic idle_push();
        @(negedge clk);
        push = 1'b0;
    endtask

    // wait until every owed flag has been checked
    task automatic drain();
        idle_push();
        while (cull_due.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [COORD_W-1:0] any_val(input int kind);
        case (kind)
            0:       return $urandom;
            1:       return int'($urandom_range(0, 32'h40000)) - 32'sh20000;
            2:       return int'($urandom_range(0, 32'h2000000)) - 32'sh1000000;
            default: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    function automatic item_t load_item(input logic [1:0] col, input int kind);
        item_t it;
        it.act = ACT_LOAD;
        it.col = col;
        it.mx  = any_val(kind);
        it.my  = any_val(kind);
        it.mz  = any_val(kind);
        it.mw  = any_val(kind);
        // box fields ride along unused
        for (int k = 0; k < 3; k++)
        begin
            it.lo[k] = $urandom;
            it.hi[k] = $urandom;
        end
        return it;
    endfunction

    // random box; for kinds other than 0 usually well-formed, min above max is left in on purpose
    function automatic item_t box_item(input int kind);
        item_t                     it;
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        it     = load_item(2'($urandom_range(0, 3)), 0);
        it.act = ACT_TEST;
        for (int k = 0; k < 3; k++)
        begin
            a = any_val(kind);
            b = any_val(kind);
            if (kind != 0 && $urandom_range(0, 9) != 0 && a > b)
            begin
                it.lo[k] = b;
                it.hi[k] = a;
            end
            else
            begin
                it.lo[k] = a;
                it.hi[k] = b;
            end
        end
        return it;
    endfunction

    // receiver: pop changes at the falling edge, a transfer is checked at the
    // rising edge where it happens
    initial
    begin : result_side
        int stall;
        int held;
        logic want;
        stall = 0;
        pop   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // long hold-off so the block fills and stalls its input
                pop  = 1'b0;
                held = 0;
                while (held < HOLD_LEN)
                begin
                    @(negedge clk);
                    held++;
                end
                hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                stall--;
                want = 1'b0;
            end
            else
            begin
                want = 1'b1;
                case ($urandom_range(0, 19))
                    0, 1, 2: stall = $urandom_range(1, 3);
                    3:       stall = $urandom_range(8, 25);
                    default: stall = 0;
                endcase
            end
            pop = want;
            @(posedge clk);
            if (pop && !empty)
            begin
                if (cull_due.size() == 0)
                begin
                    $display("%0t: culled transfer with nothing expected, actual %0b",
                             $time, culled);
                    errs++;
                end
                else if (culled !== cull_due[0])
                begin
                    $display("%0t: culled mismatch, expected %0b actual %0b",
                             $time, cull_due[0], culled);
                    errs++;
                    void'(cull_due.pop_front());
                end
                else
                    void'(cull_due.pop_front());
            end
        end
    end

    // a box against the all-zero table right after reset is never culled
    task automatic test_reset_box();
        item_t it;
        it = box_item(0);
        send_item(it);
        it = box_item(3);
        send_item(it);
    endtask

    // column loads at the field extremes, each column, then boxes on the extreme planes
    task automatic test_load_extremes();
        item_t it;
        for (int c = 0; c < 4; c++)
        begin
            it = load_item(2'(c), 3);
            send_item(it);
        end
        it    = load_item(2'd0, 3);
        it.mx = 32'sh80000000;
        it.mw = 32'sh80000000;
        send_item(it);
        it    = load_item(2'd3, 3);
        it.mx = 32'sh7fffffff;
        it.mw = 32'sh7fffffff;
        it.my = 32'sh80000000;
        send_item(it);
        for (int n = 0; n < 4; n++)
        begin
            it = box_item(3);
            send_item(it);
        end
    endtask

    // partly loaded table: one column replaced, the rest keep old entries
    task automatic test_partial_load();
        item_t it;
        it = load_item(2'd2, 1);
        send_item(it);
        it = box_item(1);
        send_item(it);
        it = load_item(2'd1, 0);
        send_item(it);
        it = box_item(2);
        send_item(it);
    endtask

    // corners used as given when min lies above max
    task automatic test_min_above_max();
        item_t it;
        it = box_item(1);
        for (int k = 0; k < 3; k++)
        begin
            it.lo[k] = 32'sh7fffffff;
            it.hi[k] = 32'sh80000000;
        end
        send_item(it);
        it = box_item(1);
        for (int k = 0; k < 3; k++)
        begin
            it.lo[k] = 32'sh00010000;
            it.hi[k] = -32'sh00010000;
        end
        send_item(it);
    endtask

    // fields of the other action carry noise and must change nothing
    task automatic test_unused_fields();
        item_t it;
        it = load_item(2'd0, 1);
        send_item(it);
        it     = box_item(1);
        it.col = 2'd3;
        it.mx  = 32'sh7fffffff;
        it.mw  = 32'sh80000000;
        send_item(it);
    endtask

    // a matrix load followed by a run of boxes, with noise mixed in
    task automatic test_random_frames(input int budget);
        item_t it;
        int    kind;
        int    nbox;
        int    sent;
        sent = 0;
        while (sent < budget)
        begin
            kind = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(0, 3);
            for (int c = 0; c < 4; c++)
            begin
                // now and then a column is skipped and keeps the old entries
                if (c == 0 || $urandom_range(0, 15) != 0)
                begin
                    it = load_item(2'(c), kind);
                    send_item(it);
                    sender_gap();
                    sent++;
                end
            end
            nbox = $urandom_range(8, 30);
            for (int n = 0; n < nbox; n++)
            begin
                case ($urandom_range(0, 19))
                    0:       it = load_item(2'($urandom_range(0, 3)), $urandom_range(0, 3));
                    1:       it = box_item(0);
                    2:       it = box_item(3);
                    default: it = box_item($urandom_range(1, 2));
                endcase
                send_item(it);
                sender_gap();
                sent++;
            end
        end
    endtask

    // receiver holds off while the sender keeps offering, then the sender waits it out
    task automatic test_pressure();
        item_t it;
        hold_req = 1'b1;
        for (int n = 0; n < 16; n++)
        begin
            it = box_item(1);
            send_item(it);
        end
        drain();
    endtask

    initial
    begin
        errs         = 0;
        cycles       = 0;
        hold_req     = 1'b0;
        rst_n        = 1'b0;
        push         = 1'b0;
        action       = ACT_LOAD;
        column_index = '0;
        matrix_row_x = '0;
        matrix_row_y = '0;
        matrix_row_z = '0;
        matrix_row_w = '0;
        box_min_x    = '0;
        box_min_y    = '0;
        box_min_z    = '0;
        box_max_x    = '0;
        box_max_y    = '0;
        box_max_z    = '0;
        for (int i = 0; i < NUM_PLANES*4; i++)
            plane_tab[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_box();
        test_load_extremes();
        test_partial_load();
        test_min_above_max();
        test_unused_fields();
        drain();
        test_random_frames(400);
        test_pressure();
        test_random_frames(450);
        test_pressure();

        drain();
        repeat (20) @(posedge clk);
        if (errs == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
sv/fac_pkg.sv
sv/fac_front.sv
sv/fac_back.sv
sv/frustum_aabb_cull_unit.sv
tb/tb_frustum_aabb_cull_unit.sv
